FILE: hdl/hsf_pkg.sv
// hsf_pkg: shared types and constants for the history stack and saved fifo
// no dependencies; imported by every other file of the block except hsf_ram
`default_nettype none

package hsf_pkg;

   localparam int REQ_W   = 3;
   localparam int HEAD_W  = 16;
   localparam int REST_W  = 64;
   localparam int COUNT_W = 7;
   localparam int ENTRY_W = HEAD_W + REST_W;

   typedef enum logic [REQ_W-1:0] {
      REQ_OPEN    = 3'd0,
      REQ_CURRENT = 3'd1,
      REQ_BACK    = 3'd2,
      REQ_CLEAR   = 3'd3,
      REQ_SAVE    = 3'd4,
      REQ_READ    = 3'd5
   } req_code_type;

   typedef struct packed {
      logic [HEAD_W-1:0] head;
      logic [REST_W-1:0] rest;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } hist_cmd_type;

   typedef struct packed {
      logic enq;
      logic deq;
   } saved_cmd_type;

endpackage

`default_nettype wire

FILE: hdl/hsf_if.sv
// hsf_req_if, hsf_rsp_if: valid/ready channels for requests and results
// depends on hsf_pkg
`default_nettype none

interface hsf_req_if import hsf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [HEAD_W-1:0] entry_head;
   logic [REST_W-1:0] entry_rest;

   modport source (output valid, output req_type, output entry_head, output entry_rest,
                   input ready);
   modport sink   (input valid, input req_type, input entry_head, input entry_rest,
                   output ready);
endinterface

interface hsf_rsp_if import hsf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               is_null;
   logic [COUNT_W-1:0] count;
   logic [HEAD_W-1:0]  out_head;
   logic [REST_W-1:0]  out_rest;
   logic               overflow;

   modport source (output valid, output is_null, output count, output out_head,
                   output out_rest, output overflow, input ready);
   modport sink   (input valid, input is_null, input count, input out_head,
                   input out_rest, input overflow, output ready);
endinterface

`default_nettype wire

FILE: hdl/hsf_ram.sv
// hsf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module hsf_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/hsf_history.sv
// hsf_history: lifo history with top entry in registers, the rest in ram
// depends on hsf_pkg and hsf_ram
`default_nettype none

module hsf_history import hsf_pkg::*; #(
   parameter int HISTORY_DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire hist_cmd_type                         cmd,
   input  wire entry_type                            push_entry,
   output logic [$clog2(HISTORY_DEPTH + 1)-1:0]      depth,
   output entry_type                                 top,
   output entry_type                                 below
);

   localparam int HDW = $clog2(HISTORY_DEPTH + 1);
   localparam int HAW = $clog2(HISTORY_DEPTH);

   logic [HDW-1:0] depth_ff, depth_in;
   entry_type      top_ff, top_in;
   logic [HDW-1:0] rd_addr_full;
   logic [ENTRY_W-1:0] rd_data;

   // read address tracks the entry just under the next top
   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + HDW'(1);
         top_in   = push_entry;
      end else if (cmd.pop) begin
         depth_in = depth_ff - HDW'(1);
         top_in   = below;
      end
      rd_addr_full = depth_in - HDW'(2);
   end

   hsf_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (depth_ff[HAW-1:0]),
      .wr_data (push_entry),
      .rd_addr (rd_addr_full[HAW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   assign depth = depth_ff;
   assign top   = top_ff;
   assign below = entry_type'(rd_data);

endmodule

`default_nettype wire

FILE: hdl/hsf_saved.sv
// hsf_saved: circular fifo of saved entries in ram with head prefetch and bypass
// depends on hsf_pkg and hsf_ram
`default_nettype none

module hsf_saved import hsf_pkg::*; #(
   parameter int SAVED_DEPTH = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire saved_cmd_type                      cmd,
   input  wire entry_type                          enq_entry,
   output logic [$clog2(SAVED_DEPTH + 1)-1:0]      count,
   output entry_type                               head
);

   localparam int SCW = $clog2(SAVED_DEPTH + 1);
   localparam int SAW = $clog2(SAVED_DEPTH);

   logic [SAW-1:0] rptr_ff, rptr_in;
   logic [SAW-1:0] wptr_ff, wptr_in;
   logic [SCW-1:0] count_ff, count_in;
   logic           fwd_ff, fwd_in;
   entry_type      fwd_data_ff;
   logic [ENTRY_W-1:0] rd_data;

   always_comb begin
      rptr_in  = rptr_ff;
      wptr_in  = wptr_ff;
      count_in = count_ff;
      if (cmd.enq) begin
         wptr_in  = (wptr_ff == SAW'(SAVED_DEPTH - 1)) ? '0 : wptr_ff + SAW'(1);
         count_in = count_ff + SCW'(1);
      end
      if (cmd.deq) begin
         rptr_in  = (rptr_ff == SAW'(SAVED_DEPTH - 1)) ? '0 : rptr_ff + SAW'(1);
         count_in = count_ff - SCW'(1);
      end
      // write lands on the slot the ram is reading this cycle
      fwd_in = cmd.enq && (wptr_ff == rptr_in);
   end

   hsf_ram #(.WIDTH(ENTRY_W), .DEPTH(SAVED_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.enq),
      .wr_addr (wptr_ff),
      .wr_data (enq_entry),
      .rd_addr (rptr_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff  <= '0;
         wptr_ff  <= '0;
         count_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
         count_ff <= count_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_in) begin
         fwd_data_ff <= enq_entry;
      end
   end

   assign count = count_ff;
   assign head  = fwd_ff ? fwd_data_ff : entry_type'(rd_data);

endmodule

`default_nettype wire

FILE: hdl/history_stack_and_saved_fifo.sv
// history_stack_and_saved_fifo: top level, request register, decode, result register
// depends on hsf_pkg, hsf_if, hsf_history, hsf_saved
//
//   channel   dir   handshake        payload
//   req_chan  in    valid / ready    req_type, entry_head, entry_rest
//   rsp_chan  out   valid / ready    is_null, count, out_head, out_rest, overflow
//
// one request per cycle sustained while rsp_chan is ready; rsp_chan.valid rises after the request
// transfer has passed the request register and then the result register
// the entry under the stack top and the fifo head are prefetched from the single read port of each ram
// reset is synchronous and empties both stores at once, no clearing pass
// while a result waits on rsp_chan the request register takes one more transfer,
// then req_chan.ready stays low until the result is taken
`default_nettype none

module history_stack_and_saved_fifo import hsf_pkg::*; #(
   parameter int HISTORY_DEPTH = 64,
   parameter int SAVED_DEPTH   = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   hsf_req_if.sink   req_chan,
   hsf_rsp_if.source rsp_chan
);

   localparam int HDW = $clog2(HISTORY_DEPTH + 1);
   localparam int SCW = $clog2(SAVED_DEPTH + 1);

   logic             in_valid_ff, in_valid_in;
   logic [REQ_W-1:0] req_type_ff;
   entry_type        entry_ff;
   logic             accept, advance, fire;

   hist_cmd_type     hist_cmd;
   saved_cmd_type    saved_cmd;
   logic [HDW-1:0]   hist_depth, hist_depth_inc;
   entry_type        hist_top, hist_below;
   logic [SCW-1:0]   saved_count, saved_count_inc;
   entry_type        saved_head;
   logic             hist_empty, hist_full, saved_empty, saved_full;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               is_null_ff, is_null_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   entry_type          out_entry_ff, out_entry_in;
   logic               overflow_ff, overflow_in;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   assign hist_empty      = (hist_depth == '0);
   assign hist_full       = (hist_depth == HDW'(HISTORY_DEPTH));
   assign hist_depth_inc  = hist_depth + HDW'(1);
   assign saved_empty     = (saved_count == '0);
   assign saved_full      = (saved_count == SCW'(SAVED_DEPTH));
   assign saved_count_inc = saved_count + SCW'(1);

   always_comb begin
      hist_cmd     = '0;
      saved_cmd    = '0;
      is_null_in   = 1'b0;
      count_in     = '0;
      out_entry_in = '0;
      overflow_in  = 1'b0;
      case (req_code_type'(req_type_ff))
         REQ_OPEN: begin
            hist_cmd.push = !hist_full;
            overflow_in   = hist_full;
            count_in      = hist_full ? COUNT_W'(hist_depth) : COUNT_W'(hist_depth_inc);
         end
         REQ_CURRENT: begin
            is_null_in = hist_empty;
            if (!hist_empty) begin
               out_entry_in = hist_top;
            end
         end
         REQ_BACK: begin
            hist_cmd.pop = !hist_empty;
            is_null_in   = (hist_depth < HDW'(2));
            if (!is_null_in) begin
               out_entry_in = hist_below;
            end
         end
         REQ_CLEAR: begin
            hist_cmd.clear = 1'b1;
            count_in       = COUNT_W'(hist_depth);
         end
         REQ_SAVE: begin
            if (!hist_empty) begin
               saved_cmd.enq = !saved_full;
               overflow_in   = saved_full;
            end
            count_in = saved_cmd.enq ? COUNT_W'(saved_count_inc) : COUNT_W'(saved_count);
         end
         REQ_READ: begin
            saved_cmd.deq = !saved_empty;
            is_null_in    = saved_empty;
            if (!saved_empty) begin
               out_entry_in = saved_head;
            end
         end
         default: begin
         end
      endcase
      if (!fire) begin
         hist_cmd  = '0;
         saved_cmd = '0;
      end
   end

   hsf_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_history (
      .clock      (clock),
      .reset      (reset),
      .cmd        (hist_cmd),
      .push_entry (entry_ff),
      .depth      (hist_depth),
      .top        (hist_top),
      .below      (hist_below)
   );

   hsf_saved #(.SAVED_DEPTH(SAVED_DEPTH)) u_saved (
      .clock     (clock),
      .reset     (reset),
      .cmd       (saved_cmd),
      .enq_entry (hist_top),
      .count     (saved_count),
      .head      (saved_head)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_type_ff     <= req_chan.req_type;
         entry_ff.head   <= req_chan.entry_head;
         entry_ff.rest   <= req_chan.entry_rest;
      end
      if (fire) begin
         is_null_ff   <= is_null_in;
         count_ff     <= count_in;
         out_entry_ff <= out_entry_in;
         overflow_ff  <= overflow_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_null  = is_null_ff;
   assign rsp_chan.count    = count_ff;
   assign rsp_chan.out_head = out_entry_ff.head;
   assign rsp_chan.out_rest = out_entry_ff.rest;
   assign rsp_chan.overflow = overflow_ff;

   // history depth steps up by one on every push
   assert property (@(posedge clock) disable iff (reset)
      hist_cmd.push |=> hist_depth == $past(hist_depth) + HDW'(1))
      else $error("history depth did not advance on push");

   // fifo never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      saved_count <= SCW'(SAVED_DEPTH))
      else $error("saved fifo count beyond depth");

   // a new result only appears after a request was processed
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("result without processed request");

   // read from an empty fifo reports null
   assert property (@(posedge clock) disable iff (reset)
      fire && (req_type_ff == REQ_READ) && saved_empty |=> rsp_chan.is_null)
      else $error("read on empty fifo not flagged null");

endmodule

`default_nettype wire
